// File: src/ipid_pkg.sv
package ipid_pkg;

	// Width of the kept, milli-scaled controller output.
	localparam int ACC_W = 26;

	// Width of the configuration and output words.
	localparam int WORD_W = 16;

	// Width of the configuration register index.
	localparam int IDX_W = 3;

	typedef logic [IDX_W-1:0] reg_idx_t;

	// Configuration register indexes.
	localparam reg_idx_t REG_GAIN_P     = 3'd0;
	localparam reg_idx_t REG_GAIN_I     = 3'd1;
	localparam reg_idx_t REG_GAIN_D     = 3'd2;
	localparam reg_idx_t REG_LIMIT_LOW  = 3'd3;
	localparam reg_idx_t REG_LIMIT_HIGH = 3'd4;

	// Gains and limits are scaled by one thousand.
	localparam logic signed [ACC_W-1:0] MILLI = 26'sd1000;
	localparam logic [ACC_W-1:0] ROUND_HALF = 26'd500;

	// Reset values of the scaled limits (-1000 and 1000 times 1000).
	localparam logic signed [ACC_W-1:0] LIMIT_LOW_RST  = -26'sd1000000;
	localparam logic signed [ACC_W-1:0] LIMIT_HIGH_RST = 26'sd1000000;

	// Division by 1000 as a multiply by ceil(2^36 / 1000) and a shift by 36.
	// The error term 264 is below 2^(36-26), so the quotient is exact for
	// every magnitude below 2^26.
	localparam int RECIP_W = 27;
	localparam int RECIP_SHIFT = 36;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

	// Width of the rounded quotient magnitude.
	localparam int Q_W = 17;

endpackage

// File: src/ipid_sample_if.sv
interface ipid_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic signed [SAMPLE_WIDTH-1:0] setpoint;
	logic signed [SAMPLE_WIDTH-1:0] measurement;

	modport source (output valid, output cmd, output setpoint, output measurement,
		input ready);
	modport sink (input valid, input cmd, input setpoint, input measurement,
		output ready);
endinterface

// File: src/ipid_result_if.sv
interface ipid_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ipid_pkg::WORD_W-1:0]   drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

// File: src/ipid_cfg_if.sv
interface ipid_cfg_if;
	logic                          valid;
	logic                          ready;
	ipid_pkg::reg_idx_t            index;
	logic [ipid_pkg::WORD_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/incremental_pid_controller_top.sv
// Incremental (velocity-form) PID controller with gains scaled by 1000.
// The sample channel carries one beat per control step: cmd 0 computes a step
// from setpoint and measurement, cmd 1 clears the kept output and the error
// history. Every sample beat produces exactly one beat on the result channel,
// carrying the clamped, rounded drive value (0 after a clear).
// The cfg channel writes gains and limits; it is always ready and is meant to
// be used only while no sample is in flight. Unknown indexes are ignored.
// An accepted beat passes the difference, product, increment, kept-output,
// magnitude and result registers. Throughput is one beat per cycle unless the
// receiver stalls: error history updates at the input register, the kept output
// in one add-and-clamp stage, so consecutive samples follow without gaps.
// The six stages advance together. When the receiver holds ready low with a
// result waiting, the whole pipeline holds and sample ready drops in the same
// cycle; no beat is lost or repeated. Ready returns as soon as the result
// register empties or is taken.
// Reset clears the gains, sets the limits to -1000 and 1000, zeroes the kept
// output and error history, and empties the pipeline.
module incremental_pid_controller_top #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ipid_cfg_if.sink      cfg,
	ipid_sample_if.sink   sample,
	ipid_result_if.source result
);

	localparam int ACC_W = ipid_pkg::ACC_W;
	localparam int WORD_W = ipid_pkg::WORD_W;
	localparam int ERR_W = SAMPLE_WIDTH + 1;
	localparam int DP_W = SAMPLE_WIDTH + 2;
	localparam int DD_W = SAMPLE_WIDTH + 3;
	localparam int PROD_W = SAMPLE_WIDTH + 19;
	localparam int SUM_W = SAMPLE_WIDTH + 22;
	localparam int MUL_W = ACC_W + ipid_pkg::RECIP_W;

	// Configuration registers. The limits are kept already scaled by 1000.
	logic signed [WORD_W-1:0] gain_p_q;
	logic signed [WORD_W-1:0] gain_i_q;
	logic signed [WORD_W-1:0] gain_d_q;
	logic signed [ACC_W-1:0]  lim_lo_q;
	logic signed [ACC_W-1:0]  lim_hi_q;
	logic signed [ACC_W-1:0]  cfg_scaled;

	// Controller state.
	logic signed [ERR_W-1:0] e1_q;
	logic signed [ERR_W-1:0] e2_q;
	logic signed [ACC_W-1:0] accum_q;

	// Pipeline valid bits and control.
	logic [5:0] vld_q;
	logic       adv;
	logic       accept;

	// Stage 1: error differences.
	logic                    clr_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic signed [DP_W-1:0]  dp_s1;
	logic signed [DD_W-1:0]  dd_s1;

	// Stage 2: gain products.
	logic                     clr_s2;
	logic signed [PROD_W-1:0] pp_s2;
	logic signed [PROD_W-1:0] pi_s2;
	logic signed [PROD_W-1:0] pd_s2;

	// Stage 3: increment.
	logic                    clr_s3;
	logic signed [SUM_W-1:0] delta_s3;

	// Stage 5: magnitude for rounding.
	logic                neg_s5;
	logic [ACC_W-1:0]    mag_s5;

	// Stage 6: result register.
	logic signed [WORD_W-1:0] drive_q;

	// Combinational terms.
	logic signed [ERR_W-1:0] err;
	logic signed [SUM_W-1:0] next_sum;
	logic signed [SUM_W-1:0] lo_ext;
	logic signed [SUM_W-1:0] hi_ext;
	logic signed [ACC_W-1:0] next_acc;
	logic [ACC_W-1:0]        acc_abs;
	logic [MUL_W-1:0]        recip_prod;
	logic [ipid_pkg::Q_W-1:0] quot;

	// All stages move together whenever the result register can take a beat.
	assign adv    = !vld_q[5] || result.ready;
	assign accept = sample.valid && adv;

	assign sample.ready = adv;
	assign result.valid = vld_q[5];
	assign result.drive = drive_q;
	assign cfg.ready    = 1'b1;

	// Configuration writes.
	assign cfg_scaled = ACC_W'($signed(cfg.data)) * ipid_pkg::MILLI;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			lim_lo_q <= ipid_pkg::LIMIT_LOW_RST;
			lim_hi_q <= ipid_pkg::LIMIT_HIGH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ipid_pkg::REG_GAIN_P:     gain_p_q <= $signed(cfg.data);
				ipid_pkg::REG_GAIN_I:     gain_i_q <= $signed(cfg.data);
				ipid_pkg::REG_GAIN_D:     gain_d_q <= $signed(cfg.data);
				ipid_pkg::REG_LIMIT_LOW:  lim_lo_q <= cfg_scaled;
				ipid_pkg::REG_LIMIT_HIGH: lim_hi_q <= cfg_scaled;
				default: begin
				end
			endcase
		end
	end

	// The error of the incoming sample and the history it shifts into.
	assign err = ERR_W'(sample.setpoint) - ERR_W'(sample.measurement);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
		end else if (accept) begin
			if (sample.cmd) begin
				e1_q <= '0;
				e2_q <= '0;
			end else begin
				e1_q <= err;
				e2_q <= e1_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[4:0], sample.valid};
		end
	end

	// Payload stages 1 to 3.
	always_ff @(posedge clk) begin
		if (adv) begin
			clr_s1 <= sample.cmd;
			err_s1 <= err;
			dp_s1  <= DP_W'(err) - DP_W'(e1_q);
			dd_s1  <= DD_W'(err) - (DD_W'(e1_q) <<< 1) + DD_W'(e2_q);

			clr_s2 <= clr_s1;
			pp_s2  <= PROD_W'(gain_p_q) * PROD_W'(dp_s1);
			pi_s2  <= PROD_W'(gain_i_q) * PROD_W'(err_s1);
			pd_s2  <= PROD_W'(gain_d_q) * PROD_W'(dd_s1);

			clr_s3   <= clr_s2;
			delta_s3 <= SUM_W'(pp_s2) + SUM_W'(pi_s2) + SUM_W'(pd_s2);
		end
	end

	// Stage 4 is the kept output itself: add the increment, then clamp with the
	// upper limit tested first so that crossed limits resolve the same way.
	assign next_sum = SUM_W'(accum_q) + delta_s3;
	assign lo_ext   = SUM_W'(lim_lo_q);
	assign hi_ext   = SUM_W'(lim_hi_q);

	always_comb begin
		if (next_sum > hi_ext) begin
			next_acc = lim_hi_q;
		end else if (next_sum < lo_ext) begin
			next_acc = lim_lo_q;
		end else begin
			next_acc = next_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (adv && vld_q[2]) begin
			accum_q <= clr_s3 ? '0 : next_acc;
		end
	end

	// Stage 5 reads the kept output while its beat sits in stage 4; rounding
	// half away from zero works on the magnitude.
	assign acc_abs = accum_q[ACC_W-1] ? ACC_W'(-accum_q) : ACC_W'(accum_q);

	// Stage 6: divide by 1000 through the reciprocal and restore the sign.
	assign recip_prod = MUL_W'(mag_s5) * MUL_W'(ipid_pkg::RECIP_1000);
	assign quot       = recip_prod[ipid_pkg::RECIP_SHIFT +: ipid_pkg::Q_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s5 <= accum_q[ACC_W-1];
			mag_s5 <= acc_abs + ipid_pkg::ROUND_HALF;

			if (neg_s5) begin
				drive_q <= WORD_W'(ipid_pkg::Q_W'(0) - quot);
			end else begin
				drive_q <= WORD_W'(quot);
			end
		end
	end

endmodule
